### sv/nnls_pkg.sv
// Shared types and constants for the nearest-neighbor linear scan block.
// No dependencies; imported by the distance cell, the best tracker and the top level.
package nnls_pkg;

   // Field widths fixed by the interface
   localparam int COORD_W   = 16;          // signed Q8.8 coordinate
   localparam int SQ_W      = 2 * COORD_W; // one squared difference
   localparam int DIST_W    = 35;          // sum of up to eight squares, Q19.16
   localparam int NIDX_W    = 10;          // reported nearest index
   localparam int DIMS_W    = 4;           // dimension register
   localparam int CMD_W     = 2;

   localparam logic [DIMS_W-1:0] DIMS_RESET = 4'd5;

   // Request commands
   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

endpackage

### sv/nnls_cell.sv
// One cell of the distance chain: owns one coordinate of every stored point
// and of the query, adds its squared difference to the running sum. Uses nnls_pkg.
module nnls_cell import nnls_pkg::*; #(
   parameter int DEPTH = 1024,
   parameter int IDX_W = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   // coordinate writes
   input  logic                      st_we,
   input  logic [IDX_W-1:0]          st_addr,
   input  logic                      q_we,
   input  logic signed [COORD_W-1:0] wr_data,
   // this coordinate takes part in the distance
   input  logic                      act,
   // chain in: index, and the partial sum that meets this cell's registered square
   input  logic                      valid_in,
   input  logic [IDX_W-1:0]          idx_in,
   input  logic [DIST_W-1:0]         sum_in,
   // chain out: registered index, and the sum after the read, square and add registers
   output logic                      valid_out,
   output logic [IDX_W-1:0]          idx_out,
   output logic [DIST_W-1:0]         sum_out,
   // index that goes with sum_out
   output logic                      res_valid,
   output logic [IDX_W-1:0]          res_idx
);

   logic signed [COORD_W-1:0] mem [DEPTH];
   logic signed [COORD_W-1:0] rd_data_ff;
   logic signed [COORD_W-1:0] q_ff;
   logic                      v1_ff, v2_ff, v3_ff;
   logic [IDX_W-1:0]          idx1_ff, idx2_ff, idx3_ff;
   logic [SQ_W-1:0]           sq_ff, sq_in;
   logic [DIST_W-1:0]         sum_ff;
   logic signed [COORD_W:0]   diff;
   logic [COORD_W:0]          mag;

   // point coordinate memory, registered read
   always_ff @(posedge clock) begin
      if (st_we) begin
         mem[st_addr] <= wr_data;
      end
      if (valid_in) begin
         rd_data_ff <= mem[idx_in];
      end
   end

   // query coordinate
   always_ff @(posedge clock) begin
      if (q_we) begin
         q_ff <= wr_data;
      end
   end

   // |q - p| squared; an unused coordinate adds nothing
   always_comb begin
      diff  = {q_ff[COORD_W-1], q_ff} - {rd_data_ff[COORD_W-1], rd_data_ff};
      mag   = diff[COORD_W] ? (~diff + 1'b1) : diff;
      sq_in = act ? (mag[COORD_W-1:0] * mag[COORD_W-1:0]) : '0;
   end

   // payload stages
   always_ff @(posedge clock) begin
      idx1_ff <= idx_in;
      idx2_ff <= idx1_ff;
      idx3_ff <= idx2_ff;
      sq_ff   <= sq_in;
      sum_ff  <= sum_in + DIST_W'(sq_ff);
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= valid_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign valid_out = v1_ff;
   assign idx_out   = idx1_ff;
   assign sum_out   = sum_ff;
   assign res_valid = v3_ff;
   assign res_idx   = idx3_ff;

endmodule

### sv/nnls_best.sv
// Running minimum over the distances leaving the cell chain; the first index wins ties.
// Uses nnls_pkg for the distance width.
module nnls_best import nnls_pkg::*; #(
   parameter int IDX_W = 10
) (
   input  logic              clock,
   input  logic              in_valid,
   input  logic [IDX_W-1:0]  in_idx,
   input  logic [DIST_W-1:0] in_dist,
   output logic [IDX_W-1:0]  best_idx,
   output logic [DIST_W-1:0] best_dist
);

   logic [IDX_W-1:0]  best_idx_ff;
   logic [DIST_W-1:0] best_dist_ff;
   logic              take;

   // index 0 opens every scan, later points need a strictly smaller distance
   assign take = in_valid && ((in_idx == '0) || (in_dist < best_dist_ff));

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff  <= in_idx;
         best_dist_ff <= in_dist;
      end
   end

   assign best_idx  = best_idx_ff;
   assign best_dist = best_dist_ff;

endmodule

### sv/nearest_neighbor_linear_scan.sv
// Brute-force nearest neighbor search over up to MAX_POINTS stored points of
// 1..MAX_DIM signed Q8.8 coordinates. Clear, load and non-final query requests
// are taken without a stall. The final coordinate of a query starts a scan:
// stored point indexes enter a chain of MAX_DIM cells one per cycle, each cell
// adds its squared coordinate difference, and a minimum tracker follows the
// chain. Requests stall while points enter the chain, while it drains and
// until the result is loaded; an empty store skips the scan and stalls only
// until its result is loaded. Either wait grows while an earlier result still
// sits unaccepted in the output register. A finished result waits there while
// further requests are taken. The store needs no clearing after reset.
module nearest_neighbor_linear_scan import nnls_pkg::*; #(
   parameter int MAX_POINTS = 1024,
   parameter int MAX_DIM    = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [CMD_W-1:0]          req_cmd,
   input  logic signed [COORD_W-1:0] req_coord_value,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_found,
   output logic [NIDX_W-1:0]         rsp_nearest_index,
   output logic [DIST_W-1:0]         rsp_nearest_dist_sq,
   // dimension register
   input  logic                      csr_wr_en,
   input  logic [DIMS_W-1:0]         csr_wr_data
);

   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int POS_W = $clog2(MAX_DIM + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   state_type          state_ff;
   logic [DIMS_W-1:0]  dims_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [POS_W-1:0]   lpos_ff, qpos_ff;
   logic [IDX_W-1:0]   scan_ff;
   logic               found_ff;
   logic               rsp_valid_ff, rsp_found_ff;
   logic [NIDX_W-1:0]  rsp_idx_ff;
   logic [DIST_W-1:0]  rsp_dist_ff;

   logic [POS_W-1:0]   eff_dims, lpos_eff, qpos_eff, lpos_in, qpos_in;
   logic               acc, do_load, do_query, store_full, last_done;

   logic               ch_valid [MAX_DIM+1];
   logic [IDX_W-1:0]   ch_idx   [MAX_DIM+1];
   logic [DIST_W-1:0]  ch_sum   [MAX_DIM+1];
   logic               res_valid [MAX_DIM];
   logic [IDX_W-1:0]   res_idx   [MAX_DIM];
   logic [IDX_W-1:0]   best_idx;
   logic [DIST_W-1:0]  best_dist;

   // dimension clamped to 1..MAX_DIM
   always_comb begin
      if (dims_ff == '0) begin
         eff_dims = POS_W'(1);
      end else if (dims_ff > DIMS_W'(MAX_DIM)) begin
         eff_dims = POS_W'(MAX_DIM);
      end else begin
         eff_dims = POS_W'(dims_ff);
      end
   end

   // request decode and coordinate positions
   assign req_stall  = (state_ff != ST_IDLE);
   assign acc        = req_valid && !req_stall;
   assign store_full = (count_ff >= CNT_W'(MAX_POINTS));
   assign do_load    = acc && (req_cmd == CMD_LOAD) && !store_full;
   assign do_query   = acc && (req_cmd == CMD_QUERY);
   assign lpos_eff   = (lpos_ff >= eff_dims) ? '0 : lpos_ff;
   assign qpos_eff   = (qpos_ff >= eff_dims) ? '0 : qpos_ff;
   assign lpos_in    = POS_W'(lpos_eff + 1'b1);
   assign qpos_in    = POS_W'(qpos_eff + 1'b1);

   // head of the chain
   assign ch_valid[0] = (state_ff == ST_SCAN);
   assign ch_idx[0]   = scan_ff;
   assign ch_sum[0]   = '0;

   // row of distance cells
   for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
      nnls_cell #(
         .DEPTH (MAX_POINTS),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .st_we     (do_load && (lpos_eff == POS_W'(k))),
         .st_addr   (count_ff[IDX_W-1:0]),
         .q_we      (do_query && (qpos_eff == POS_W'(k))),
         .wr_data   (req_coord_value),
         .act       (POS_W'(k) < eff_dims),
         .valid_in  (ch_valid[k]),
         .idx_in    (ch_idx[k]),
         .sum_in    (ch_sum[k]),
         .valid_out (ch_valid[k+1]),
         .idx_out   (ch_idx[k+1]),
         .sum_out   (ch_sum[k+1]),
         .res_valid (res_valid[k]),
         .res_idx   (res_idx[k])
      );
   end

   // running minimum at the end of the chain
   nnls_best #(
      .IDX_W (IDX_W)
   ) u_best (
      .clock     (clock),
      .in_valid  (res_valid[MAX_DIM-1]),
      .in_idx    (res_idx[MAX_DIM-1]),
      .in_dist   (ch_sum[MAX_DIM]),
      .best_idx  (best_idx),
      .best_dist (best_dist)
   );

   assign last_done = res_valid[MAX_DIM-1] &&
                      (CNT_W'(res_idx[MAX_DIM-1]) == count_ff - CNT_W'(1));

   // control state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dims_ff      <= DIMS_RESET;
         count_ff     <= '0;
         lpos_ff      <= '0;
         qpos_ff      <= '0;
         scan_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_wr_en) begin
            dims_ff <= csr_wr_data;
            lpos_ff <= '0;
            qpos_ff <= '0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (acc) begin
                  case (req_cmd)
                     CMD_CLEAR: begin
                        count_ff <= '0;
                        lpos_ff  <= '0;
                        qpos_ff  <= '0;
                     end
                     CMD_LOAD: begin
                        if (store_full) begin
                           lpos_ff <= '0;
                        end else if (lpos_in >= eff_dims) begin
                           lpos_ff  <= '0;
                           count_ff <= CNT_W'(count_ff + 1'b1);
                        end else begin
                           lpos_ff <= lpos_in;
                        end
                     end
                     CMD_QUERY: begin
                        if (qpos_in >= eff_dims) begin
                           qpos_ff <= '0;
                           scan_ff <= '0;
                           if (count_ff == '0) begin
                              found_ff <= 1'b0;
                              state_ff <= ST_EMIT;
                           end else begin
                              found_ff <= 1'b1;
                              state_ff <= ST_SCAN;
                           end
                        end else begin
                           qpos_ff <= qpos_in;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               // one point index into the chain per cycle
               scan_ff <= IDX_W'(scan_ff + 1'b1);
               if (CNT_W'(scan_ff) == count_ff - CNT_W'(1)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (last_done) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               // load the result once the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_found_ff <= found_ff;
                  rsp_idx_ff   <= found_ff ? NIDX_W'(best_idx) : '0;
                  rsp_dist_ff  <= found_ff ? best_dist : '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_nearest_index   = rsp_idx_ff;
   assign rsp_nearest_dist_sq = rsp_dist_ff;

`ifndef ASSERT_OFF
   // distances only leave the chain while a scan is running
   a_res_in_scan: assert property (@(posedge clock) disable iff (reset)
      res_valid[MAX_DIM-1] |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("chain result outside a scan");

   // an empty-store answer carries zero index and distance
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_nearest_index == '0 && rsp_nearest_dist_sq == '0))
      else $error("empty result with nonzero fields");

   // the point count never passes capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond capacity");

   // a scan is only started with a nonempty store
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (count_ff != '0 && found_ff))
      else $error("scan over an empty store");
`endif

endmodule
